FILE: src/gpd_pkg.sv
// ----------------------------------------------------------------------------
// gpd_pkg: shared types, constants and helpers for the grid peak detector
// Result kinds, configuration register indexes, cell position flags and the
// saturating peak-count helper.
// ----------------------------------------------------------------------------
`default_nettype none

package gpd_pkg;

  localparam int DEF_MAX_ROWS    = 1024;
  localparam int DEF_MAX_COLS    = 1024;
  localparam int DEF_SAMPLE_BITS = 16;

  // grid size after reset, both dimensions
  localparam int GRID_RESET = 3;

  localparam int TOTAL_W = 20;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

  typedef enum logic [0:0] {
    REG_GRID_ROWS = 1'b0,
    REG_GRID_COLS = 1'b1
  } cfg_reg_t;

  typedef enum logic [0:0] {
    KIND_PEAK    = 1'b0,
    KIND_SUMMARY = 1'b1
  } result_kind_t;

  // where the incoming sample sits in the grid
  typedef struct packed {
    logic last_row;
    logic last_col;
    logic row_gt0;
    logic row_gt1;
    logic col_gt0;
    logic col_gt1;
  } cell_pos_t;

  function automatic logic [TOTAL_W-1:0] sat_total(input logic [TOTAL_W-1:0] base,
                                                   input logic [1:0] inc);
    logic [TOTAL_W:0] sum;
    sum = {1'b0, base} + {{(TOTAL_W - 1){1'b0}}, inc};
    if (sum[TOTAL_W]) begin
      return TOTAL_MAX;
    end
    return sum[TOTAL_W-1:0];
  endfunction

endpackage

`default_nettype wire

FILE: src/grid_peak_detector_core.sv
// ----------------------------------------------------------------------------
// grid_peak_detector_core: strict 4-neighbor local maximum over a raster grid
// Samples register in the decision stage, result words in the result buffer.
// Throughput: one sample per cycle while samples cause no result word; a
//   sample causing words (up to 4) waits in the decision stage until the result
//   buffer is free; the buffer drains one word per cycle while out_ready is high.
// Reset: counters and peak count cleared, grid size 3 x 3; the line store is
//   not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module grid_peak_detector_core #(
  parameter int MAX_ROWS    = gpd_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS    = gpd_pkg::DEF_MAX_COLS,
  parameter int SAMPLE_BITS = gpd_pkg::DEF_SAMPLE_BITS,
  localparam int ROW_W      = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1,
  localparam int COL_W      = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1,
  localparam int MAX_DIM    = (MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS,
  localparam int CFG_W      = $clog2(MAX_DIM + 1)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  gpd_pkg::cfg_reg_t             cfg_index,
  input  logic [CFG_W-1:0]              cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [SAMPLE_BITS-1:0] sample_value,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          result_kind,
  output logic [ROW_W-1:0]              peak_row,
  output logic [COL_W-1:0]              peak_col,
  output logic signed [SAMPLE_BITS-1:0] peak_value,
  output logic [gpd_pkg::TOTAL_W-1:0]   peak_total,
  output logic                          last_of_run
);

  import gpd_pkg::*;

  localparam int ROWS_RESET = (GRID_RESET > MAX_ROWS) ? MAX_ROWS : GRID_RESET;
  localparam int COLS_RESET = (GRID_RESET > MAX_COLS) ? MAX_COLS : GRID_RESET;

  logic [CFG_W-1:0]         grid_rows;
  logic [CFG_W-1:0]         grid_cols;
  logic [ROW_W-1:0]         row_cnt;
  logic [COL_W-1:0]         col_cnt;
  logic                     accept;
  logic                     last_row;
  logic                     last_col;
  cell_pos_t                pos;
  logic [CFG_W-1:0]         rows_clamped;
  logic [CFG_W-1:0]         cols_clamped;
  logic                     wr_en;
  logic [COL_W-1:0]         wr_addr;
  logic [2*SAMPLE_BITS-1:0] wr_data;
  logic [2*SAMPLE_BITS-1:0] rd_pair;
  logic [SAMPLE_BITS-1:0]   rd_next_mid;

  assign cfg_ready = 1'b1;

  always_comb begin
    if (cfg_data == '0) begin
      rows_clamped = CFG_W'(1);
      cols_clamped = CFG_W'(1);
    end else begin
      rows_clamped = (cfg_data > CFG_W'(MAX_ROWS)) ? CFG_W'(MAX_ROWS) : cfg_data;
      cols_clamped = (cfg_data > CFG_W'(MAX_COLS)) ? CFG_W'(MAX_COLS) : cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_rows <= CFG_W'(ROWS_RESET);
      grid_cols <= CFG_W'(COLS_RESET);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_GRID_ROWS: grid_rows <= rows_clamped;
        REG_GRID_COLS: grid_cols <= cols_clamped;
        default: ;
      endcase
    end
  end

  assign accept   = in_valid && in_ready;
  // a counter past a shrunken size counts as being on the last row or column
  assign last_row = (CFG_W'(row_cnt) + CFG_W'(1)) >= grid_rows;
  assign last_col = (CFG_W'(col_cnt) + CFG_W'(1)) >= grid_cols;

  always_comb begin
    pos.last_row = last_row;
    pos.last_col = last_col;
    pos.row_gt0  = (row_cnt != '0);
    pos.row_gt1  = (row_cnt > ROW_W'(1));
    pos.col_gt0  = (col_cnt != '0);
    pos.col_gt1  = (col_cnt > COL_W'(1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_cnt <= '0;
      col_cnt <= '0;
    end else if (accept) begin
      if (last_col) begin
        col_cnt <= '0;
        row_cnt <= last_row ? '0 : row_cnt + ROW_W'(1);
      end else begin
        col_cnt <= col_cnt + COL_W'(1);
      end
    end
  end

  gpd_line_mem #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .MAX_COLS    (MAX_COLS),
    .COL_W       (COL_W)
  ) u_line_mem (
    .clk      (clk),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .rd_en    (accept),
    .rd_addr0 (col_cnt),
    .rd_addr1 (col_cnt + COL_W'(1)),
    .rd_pair0 (rd_pair),
    .rd_mid1  (rd_next_mid)
  );

  gpd_peak_eval #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .ROW_W       (ROW_W),
    .COL_W       (COL_W)
  ) u_peak_eval (
    .clk         (clk),
    .rst         (rst),
    .load        (accept),
    .load_sample (sample_value),
    .load_row    (row_cnt),
    .load_col    (col_cnt),
    .load_pos    (pos),
    .rd_pair     (rd_pair),
    .rd_next_mid (rd_next_mid),
    .stage_ready (in_ready),
    .wr_en       (wr_en),
    .wr_addr     (wr_addr),
    .wr_data     (wr_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .result_kind (result_kind),
    .peak_row    (peak_row),
    .peak_col    (peak_col),
    .peak_value  (peak_value),
    .peak_total  (peak_total),
    .last_of_run (last_of_run)
  );

endmodule

`default_nettype wire

FILE: src/gpd_line_mem.sv
// ----------------------------------------------------------------------------
// gpd_line_mem: line store for the two previous rows
// One entry per column holds {upper row, middle row}. One write port, two
// registered read ports; a read of the entry written in the same cycle
// returns the new data.
// ----------------------------------------------------------------------------
`default_nettype none

module gpd_line_mem #(
  parameter int SAMPLE_BITS = 16,
  parameter int MAX_COLS    = 1024,
  parameter int COL_W       = 10
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [COL_W-1:0]         wr_addr,
  input  logic [2*SAMPLE_BITS-1:0] wr_data,
  input  logic                     rd_en,
  input  logic [COL_W-1:0]         rd_addr0,
  input  logic [COL_W-1:0]         rd_addr1,
  output logic [2*SAMPLE_BITS-1:0] rd_pair0,
  output logic [SAMPLE_BITS-1:0]   rd_mid1
);

  logic [2*SAMPLE_BITS-1:0] mem [MAX_COLS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // bypass the word being written so a read never sees stale data
  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (wr_en && (wr_addr == rd_addr0)) begin
        rd_pair0 <= wr_data;
      end else begin
        rd_pair0 <= mem[rd_addr0];
      end
      if (wr_en && (wr_addr == rd_addr1)) begin
        rd_mid1 <= wr_data[SAMPLE_BITS-1:0];
      end else begin
        rd_mid1 <= mem[rd_addr1][SAMPLE_BITS-1:0];
      end
    end
  end

endmodule

`default_nettype wire

FILE: src/gpd_peak_eval.sv
// ----------------------------------------------------------------------------
// gpd_peak_eval: decision stage and result buffer
// Holds one sample with its line store data, decides the cell above, the
// cell to the left and the cell itself, writes the line store back and
// queues up to four result words that drain one per cycle while out_ready is high.
// ----------------------------------------------------------------------------
`default_nettype none

module gpd_peak_eval #(
  parameter int SAMPLE_BITS = 16,
  parameter int ROW_W       = 10,
  parameter int COL_W       = 10
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            load,
  input  logic [SAMPLE_BITS-1:0]          load_sample,
  input  logic [ROW_W-1:0]                load_row,
  input  logic [COL_W-1:0]                load_col,
  input  gpd_pkg::cell_pos_t              load_pos,
  input  logic [2*SAMPLE_BITS-1:0]        rd_pair,
  input  logic [SAMPLE_BITS-1:0]          rd_next_mid,
  output logic                            stage_ready,
  output logic                            wr_en,
  output logic [COL_W-1:0]                wr_addr,
  output logic [2*SAMPLE_BITS-1:0]        wr_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            result_kind,
  output logic [ROW_W-1:0]                peak_row,
  output logic [COL_W-1:0]                peak_col,
  output logic signed [SAMPLE_BITS-1:0]   peak_value,
  output logic [gpd_pkg::TOTAL_W-1:0]     peak_total,
  output logic                            last_of_run
);

  import gpd_pkg::*;

  localparam int NUM_SLOTS = 4;
  localparam int SLOT_UP   = 0;
  localparam int SLOT_LEFT = 1;
  localparam int SLOT_SELF = 2;
  localparam int SLOT_SUM  = 3;

  // decision stage
  logic                          b_valid;
  logic signed [SAMPLE_BITS-1:0] b_sample;
  logic [ROW_W-1:0]              b_row;
  logic [COL_W-1:0]              b_col;
  cell_pos_t                     b_pos;

  // previous-row sample left of the cursor, and the last two current-row samples
  logic signed [SAMPLE_BITS-1:0] left0;
  logic signed [SAMPLE_BITS-1:0] left1;
  logic signed [SAMPLE_BITS-1:0] left2;
  logic [TOTAL_W-1:0]            peak_count;

  // result buffer
  logic [NUM_SLOTS-1:0]          pend;
  logic [ROW_W-1:0]              slot_row   [NUM_SLOTS];
  logic [COL_W-1:0]              slot_col   [NUM_SLOTS];
  logic signed [SAMPLE_BITS-1:0] slot_value [NUM_SLOTS];
  logic [TOTAL_W-1:0]            slot_total [NUM_SLOTS];

  logic signed [SAMPLE_BITS-1:0] above;
  logic signed [SAMPLE_BITS-1:0] above2;
  logic signed [SAMPLE_BITS-1:0] above_next;
  logic                          pk_up;
  logic                          pk_left;
  logic                          pk_self;
  logic                          grid_end;
  logic [NUM_SLOTS-1:0]          hits;
  logic [TOTAL_W-1:0]            total_up;
  logic [TOTAL_W-1:0]            total_left;
  logic [TOTAL_W-1:0]            total_self;
  logic [TOTAL_W-1:0]            total_final;
  logic [1:0]                    sel;
  logic [NUM_SLOTS-1:0]          sel_oh;
  logic [NUM_SLOTS-1:0]          rest;
  logic                          buf_free;
  logic                          fire;
  logic                          pop;

  assign above      = rd_pair[SAMPLE_BITS-1:0];
  assign above2     = rd_pair[2*SAMPLE_BITS-1:SAMPLE_BITS];
  assign above_next = rd_next_mid;

  always_comb begin
    // cell above is complete once its lower neighbor arrives
    pk_up = b_pos.row_gt0 && (above > b_sample)
            && (!b_pos.row_gt1 || (above > above2))
            && (!b_pos.col_gt0 || (above > left0))
            && (b_pos.last_col || (above > above_next));
    // on the last row the left cell has no lower neighbor; its upper one is left0
    pk_left = b_pos.last_row && b_pos.col_gt0 && (left1 > b_sample)
              && (!b_pos.row_gt0 || (left1 > left0))
              && (!b_pos.col_gt1 || (left1 > left2));
    pk_self = b_pos.last_row && b_pos.last_col
              && (!b_pos.row_gt0 || (b_sample > above))
              && (!b_pos.col_gt0 || (b_sample > left1));
    grid_end = b_pos.last_row && b_pos.last_col;
    hits = {grid_end, pk_self, pk_left, pk_up};
  end

  assign total_up    = sat_total(peak_count, 2'd1);
  assign total_left  = sat_total(peak_count, 2'(pk_up) + 2'd1);
  assign total_self  = sat_total(peak_count, 2'(pk_up) + 2'(pk_left) + 2'd1);
  assign total_final = sat_total(peak_count, 2'(pk_up) + 2'(pk_left) + 2'(pk_self));

  always_comb begin
    priority if (pend[SLOT_UP]) begin
      sel = 2'(SLOT_UP);
    end else if (pend[SLOT_LEFT]) begin
      sel = 2'(SLOT_LEFT);
    end else if (pend[SLOT_SELF]) begin
      sel = 2'(SLOT_SELF);
    end else begin
      sel = 2'(SLOT_SUM);
    end
  end

  assign sel_oh   = NUM_SLOTS'(1) << sel;
  assign rest     = pend & ~sel_oh;
  assign out_valid = |pend;
  assign pop      = out_valid && out_ready;
  assign buf_free = (pend == '0) || (out_ready && (rest == '0));
  // a sample with no word to emit never waits on the buffer
  assign fire        = b_valid && ((hits == '0) || buf_free);
  assign stage_ready = !b_valid || fire;

  assign wr_en   = fire;
  assign wr_addr = b_col;
  assign wr_data = {above, b_sample};

  assign result_kind = (sel == 2'(SLOT_SUM)) ? KIND_SUMMARY : KIND_PEAK;
  assign peak_row    = slot_row[sel];
  assign peak_col    = slot_col[sel];
  assign peak_value  = slot_value[sel];
  assign peak_total  = slot_total[sel];
  assign last_of_run = (rest == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (load) begin
      b_valid <= 1'b1;
    end else if (fire) begin
      b_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      b_sample <= load_sample;
      b_row    <= load_row;
      b_col    <= load_col;
      b_pos    <= load_pos;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      left0      <= '0;
      left1      <= '0;
      left2      <= '0;
      peak_count <= '0;
    end else if (fire) begin
      left0      <= above;
      left1      <= b_sample;
      left2      <= left1;
      peak_count <= grid_end ? '0 : total_final;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= '0;
    end else if (fire && (hits != '0)) begin
      pend <= hits;
    end else if (pop) begin
      pend <= rest;
    end
  end

  // hold the slots while words are pending; only a sample with words reloads them
  always_ff @(posedge clk) begin
    if (fire && (hits != '0)) begin
      slot_row[SLOT_UP]     <= b_row - ROW_W'(1);
      slot_col[SLOT_UP]     <= b_col;
      slot_value[SLOT_UP]   <= above;
      slot_total[SLOT_UP]   <= total_up;
      slot_row[SLOT_LEFT]   <= b_row;
      slot_col[SLOT_LEFT]   <= b_col - COL_W'(1);
      slot_value[SLOT_LEFT] <= left1;
      slot_total[SLOT_LEFT] <= total_left;
      slot_row[SLOT_SELF]   <= b_row;
      slot_col[SLOT_SELF]   <= b_col;
      slot_value[SLOT_SELF] <= b_sample;
      slot_total[SLOT_SELF] <= total_self;
      slot_row[SLOT_SUM]    <= '0;
      slot_col[SLOT_SUM]    <= '0;
      slot_value[SLOT_SUM]  <= '0;
      slot_total[SLOT_SUM]  <= total_final;
    end
  end

endmodule

`default_nettype wire

FILE: src/gpd_port_checker.sv
// ----------------------------------------------------------------------------
// gpd_port_checker: port-level checks for grid_peak_detector_core
// Watches the result channel for stalled-word stability, summary word
// contents, peak count sanity and an empty result channel after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module gpd_port_checker #(
  parameter int SAMPLE_BITS = 16,
  parameter int ROW_W       = 10,
  parameter int COL_W       = 10
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic                          result_kind,
  input logic [ROW_W-1:0]              peak_row,
  input logic [COL_W-1:0]              peak_col,
  input logic signed [SAMPLE_BITS-1:0] peak_value,
  input logic [gpd_pkg::TOTAL_W-1:0]   peak_total,
  input logic                          last_of_run
);

  import gpd_pkg::*;

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(result_kind) && $stable(peak_row)
      && $stable(peak_col) && $stable(peak_value) && $stable(peak_total)
      && $stable(last_of_run))
    else $error("result word changed while stalled");

  a_summary_word: assert property (@(posedge clk) disable iff (rst)
    out_valid && (result_kind == KIND_SUMMARY) |->
      (peak_row == '0) && (peak_col == '0) && (peak_value == '0) && last_of_run)
    else $error("summary word malformed or not last of its run");

  a_peak_counted: assert property (@(posedge clk) disable iff (rst)
    out_valid && (result_kind == KIND_PEAK) |-> (peak_total != '0))
    else $error("peak word with zero running count");

  a_reset_empty: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !out_valid)
    else $error("result word offered right after reset");

endmodule

bind grid_peak_detector_core gpd_port_checker #(
  .SAMPLE_BITS (SAMPLE_BITS),
  .ROW_W       (ROW_W),
  .COL_W       (COL_W)
) u_port_checker (.*);

`default_nettype wire

FILE: tb/sv/grid_peak_detector_core_tb.sv
// ----------------------------------------------------------------------------
// grid_peak_detector_core_tb: self-checking bench for the grid peak detector
// Streams raster grids of signed samples through the core and predicts every
// peak and end-of-grid summary word in order, with random idling on both
// sides, long output stalls, and grid size writes between and inside grids.
// ----------------------------------------------------------------------------
`default_nettype none

module grid_peak_detector_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import gpd_pkg::*;

  localparam int RAND_ITEMS  = 410;
  localparam int CYCLE_LIMIT = 400000;
  localparam int STALL_LEN   = 300;
  localparam int DRAIN_WAIT  = 8;

  typedef enum int {
    STYLE_WIDE,
    STYLE_TIES,
    STYLE_EXTREME,
    STYLE_CHECKER
  } sample_style_t;

  typedef struct packed {
    result_kind_t       kind;
    logic [9:0]         row;
    logic [9:0]         col;
    logic [15:0]        value;
    logic [TOTAL_W-1:0] total;
    logic               is_last;
  } peak_word_t;

  logic                clk;
  logic                rst = 1'b1;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  cfg_reg_t            cfg_index = REG_GRID_ROWS;
  logic [10:0]         cfg_data = '0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic signed [15:0]  sample_value = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic                result_kind;
  logic [9:0]          peak_row;
  logic [9:0]          peak_col;
  logic signed [15:0]  peak_value;
  logic [TOTAL_W-1:0]  peak_total;
  logic                last_of_run;

  grid_peak_detector_core dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .sample_value (sample_value),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .result_kind  (result_kind),
    .peak_row     (peak_row),
    .peak_col     (peak_col),
    .peak_value   (peak_value),
    .peak_total   (peak_total),
    .last_of_run  (last_of_run)
  );

  // detector image: line stores, scan position, peak count, grid size
  logic signed [15:0] upper_mem  [0:1023];
  logic signed [15:0] middle_mem [0:1023];
  logic signed [15:0] left_above = '0;
  logic signed [15:0] left_here  = '0;
  int row_at   = 0;
  int col_at   = 0;
  int peak_cnt = 0;
  int rows_eff = GRID_RESET;
  int cols_eff = GRID_RESET;

  logic [15:0] sample_backlog [$];
  peak_word_t  awaited_words  [$];

  int n_queued       = 0;
  int n_accepted     = 0;
  int err_count      = 0;
  int peaks_seen     = 0;
  int summaries_seen = 0;
  int grids_done     = 0;
  int rand_items     = 0;
  int send_idle_pct  = 0;
  int recv_idle_pct  = 0;
  int stall_asked    = 0;
  int stall_served   = 0;
  int stall_left     = 0;
  int cycle_count    = 0;
  // scan position of the next sample to be queued
  int pos_r = 0;
  int pos_c = 0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic int clamp_dim(input int raw, input int max_dim);
    if (raw == 0) return 1;
    if (raw > max_dim) return max_dim;
    return raw;
  endfunction

  function automatic peak_word_t note_peak(input int row, input int col,
                                           input logic [15:0] v);
    peak_word_t w;
    if (peak_cnt < int'(TOTAL_MAX)) peak_cnt++;
    w.kind    = KIND_PEAK;
    w.row     = row[9:0];
    w.col     = col[9:0];
    w.value   = v;
    w.total   = peak_cnt[TOTAL_W-1:0];
    w.is_last = 1'b0;
    return w;
  endfunction

  // decide every cell whose last neighbor is the incoming sample
  function automatic void detect_step(input logic signed [15:0] s);
    peak_word_t         words [4];
    int                 n;
    int                 r;
    int                 c;
    logic               at_last_col;
    logic               at_last_row;
    logic               pk;
    logic signed [15:0] v;
    n = 0;
    r = row_at;
    c = col_at;
    at_last_col = (c + 1 >= cols_eff);
    at_last_row = (r + 1 >= rows_eff);
    if (r > 0) begin
      v  = middle_mem[c];
      pk = (v > s);
      if (r > 1 && v <= upper_mem[c]) pk = 1'b0;
      if (c > 0 && v <= left_above) pk = 1'b0;
      if (!at_last_col && v <= middle_mem[c + 1]) pk = 1'b0;
      if (pk) begin
        words[n] = note_peak(r - 1, c, v);
        n++;
      end
    end
    if (at_last_row) begin
      if (c > 0) begin
        v  = left_here;
        pk = (v > s);
        if (r > 0 && v <= upper_mem[c - 1]) pk = 1'b0;
        if (c > 1 && v <= middle_mem[c - 2]) pk = 1'b0;
        if (pk) begin
          words[n] = note_peak(r, c - 1, v);
          n++;
        end
      end
      if (at_last_col) begin
        pk = 1'b1;
        if (r > 0 && s <= middle_mem[c]) pk = 1'b0;
        if (c > 0 && s <= left_here) pk = 1'b0;
        if (pk) begin
          words[n] = note_peak(r, c, s);
          n++;
        end
      end
    end
    left_above    = middle_mem[c];
    left_here     = s;
    upper_mem[c]  = middle_mem[c];
    middle_mem[c] = s;
    if (at_last_col) begin
      col_at = 0;
      if (at_last_row) begin
        words[n].kind    = KIND_SUMMARY;
        words[n].row     = '0;
        words[n].col     = '0;
        words[n].value   = '0;
        words[n].total   = peak_cnt[TOTAL_W-1:0];
        words[n].is_last = 1'b0;
        n++;
        row_at   = 0;
        peak_cnt = 0;
      end else begin
        row_at = r + 1;
      end
    end else begin
      col_at = c + 1;
    end
    if (n > 0) words[n - 1].is_last = 1'b1;
    for (int i = 0; i < n; i++) awaited_words.push_back(words[i]);
  endfunction

  task automatic log_mismatch(input string msg);
    $display("mismatch @%0t: %s", $realtime, msg);
    err_count++;
  endtask

  function automatic string word_text(input peak_word_t w);
    return $sformatf("kind %0d row %0d col %0d value %0d total %0d last %0d",
                     w.kind, w.row, w.col, $signed(w.value), w.total, w.is_last);
  endfunction

  // sample driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        detect_step(sample_value);
        n_accepted++;
      end
      if (!in_valid || in_ready) begin
        if (sample_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_valid     <= 1'b1;
          sample_value <= sample_backlog.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor with its own long hold-off counter
  always @(posedge clk) begin : watch_results
    peak_word_t got;
    peak_word_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        got.kind    = result_kind_t'(result_kind);
        got.row     = peak_row;
        got.col     = peak_col;
        got.value   = peak_value;
        got.total   = peak_total;
        got.is_last = last_of_run;
        if (got.kind == KIND_SUMMARY) summaries_seen++;
        else peaks_seen++;
        if (awaited_words.size() == 0) begin
          log_mismatch({"unexpected word: ", word_text(got)});
        end else begin
          want = awaited_words.pop_front();
          if (got !== want) begin
            log_mismatch({"got ", word_text(got), " / want ", word_text(want)});
          end
        end
      end
      if (stall_asked != stall_served) begin
        stall_served = stall_asked;
        stall_left   = STALL_LEN;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d words still awaited", cycle_count,
             awaited_words.size());
    $display("tb: failure");
    $finish;
  end

  function automatic logic queue_sample(input logic [15:0] v);
    logic done;
    sample_backlog.push_back(v);
    n_queued++;
    done = 1'b0;
    if (pos_c + 1 >= cols_eff) begin
      pos_c = 0;
      if (pos_r + 1 >= rows_eff) begin
        pos_r = 0;
        done  = 1'b1;
        grids_done++;
      end else begin
        pos_r++;
      end
    end else begin
      pos_c++;
    end
    return done;
  endfunction

  function automatic logic [15:0] pick_sample(input sample_style_t style);
    logic [15:0] v;
    case (style)
      STYLE_TIES: v = 16'($urandom_range(0, 4) - 2);
      STYLE_EXTREME: begin
        case ($urandom_range(0, 4))
          0:       v = 16'h8000;
          1:       v = 16'h7fff;
          2:       v = 16'h0000;
          3:       v = 16'hffff;
          default: v = 16'h0001;
        endcase
      end
      STYLE_CHECKER: begin
        if ((pos_r + pos_c) % 2 == 0) v = 16'($urandom_range(1000, 32767));
        else v = 16'($urandom_range(0, 999));
      end
      default: v = 16'($urandom);
    endcase
    // sprinkle full-range noise into every style
    if ($urandom_range(0, 9) == 0) v = 16'($urandom);
    return v;
  endfunction

  // hold the sender until every awaited word is out, then let the core settle
  task automatic settle();
    while (n_accepted != n_queued || awaited_words.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [10:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      REG_GRID_ROWS: rows_eff = clamp_dim(int'(data), DEF_MAX_ROWS);
      default:       cols_eff = clamp_dim(int'(data), DEF_MAX_COLS);
    endcase
  endtask

  task automatic set_size(input int rows_raw, input int cols_raw);
    settle();
    write_reg(REG_GRID_ROWS, 11'(rows_raw));
    write_reg(REG_GRID_COLS, 11'(cols_raw));
  endtask

  // one grid; rows_req of zero picks size, style and maybe a mid-grid resize
  task automatic run_grid(input int rows_req, input int cols_req,
                          input sample_style_t style_req, input logic hold);
    int            rows_n;
    int            cols_n;
    int            cut;
    int            sent;
    sample_style_t style;
    logic          grid_end;
    style = style_req;
    cut   = -1;
    if (rows_req > 0) begin
      set_size(rows_req, cols_req);
    end else begin
      style = sample_style_t'($urandom_range(0, 3));
      if ($urandom_range(0, 1) == 0) begin
        case ($urandom_range(0, 19))
          0: begin
            rows_n = $urandom_range(1, 2);
            cols_n = $urandom_range(100, 240);
          end
          1: begin
            rows_n = $urandom_range(30, 60);
            cols_n = $urandom_range(1, 2);
          end
          default: begin
            rows_n = $urandom_range(1, 6);
            cols_n = $urandom_range(1, 9);
          end
        endcase
        // a zero write stands for one
        if (rows_n == 1 && $urandom_range(0, 2) == 0) rows_n = 0;
        if (cols_n == 1 && $urandom_range(0, 2) == 0) cols_n = 0;
        set_size(rows_n, cols_n);
      end
      if (rows_eff * cols_eff > 1 && $urandom_range(0, 7) == 0)
        cut = $urandom_range(1, rows_eff * cols_eff - 1);
    end
    if (hold) stall_asked++;
    sent = 0;
    do begin
      if (sent == cut) begin
        // widen only while still on the first row, so no unwritten column is read
        rows_n = $urandom_range(0, 6);
        cols_n = (pos_r == 0) ? $urandom_range(0, 9) : $urandom_range(1, cols_eff);
        set_size(rows_n, cols_n);
      end
      grid_end = queue_sample(pick_sample(style));
      sent++;
      rand_items++;
    end while (!grid_end);
  endtask

  initial begin : stimulus
    int ph;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send_idle_pct = 15;
    recv_idle_pct = 54;

    // reset size 3 x 3: extremes, ties and corner peaks
    void'(queue_sample(16'h7fff)); void'(queue_sample(16'h8000));
    void'(queue_sample(16'd5));
    void'(queue_sample(16'h8000)); void'(queue_sample(16'd100));
    void'(queue_sample(16'd100));
    void'(queue_sample(16'd7));    void'(queue_sample(16'h8000));
    void'(queue_sample(16'h7fff));

    // zero sizes act as 1 x 1: every sample is a peak plus a summary
    set_size(0, 0);
    void'(queue_sample(16'h8000));
    void'(queue_sample(16'h7fff));

    // tallest grid cut short: row counter lands past the new last row
    set_size(1024, 2);
    void'(queue_sample(16'd10)); void'(queue_sample(16'hfffb));
    void'(queue_sample(16'd20)); void'(queue_sample(16'd20));
    set_size(1, 2);
    void'(queue_sample(16'd30)); void'(queue_sample(16'hfff9));

    // oversized width acts as the maximum, then cut short past the last column
    set_size(1, 2047);
    void'(queue_sample(16'd3));  void'(queue_sample(16'd9));
    void'(queue_sample(16'hffff)); void'(queue_sample(16'h7fff));
    set_size(1, 2);
    void'(queue_sample(16'd0));

    for (ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          send_idle_pct = 15;
          recv_idle_pct = 54;
        end
        1: begin
          send_idle_pct = 54;
          recv_idle_pct = 15;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      if (ph == 1) settle();
      // stall the output while a peak-dense grid streams in
      if (ph == 2) run_grid(5, 8, STYLE_CHECKER, 1'b1);
      while (rand_items < (ph + 1) * RAND_ITEMS / 3) run_grid(0, 0, STYLE_WIDE, 1'b0);
    end

    settle();
    repeat (20) @(posedge clk);
    if (awaited_words.size() != 0)
      log_mismatch($sformatf("%0d words never arrived", awaited_words.size()));
    $display("covered %0d samples in %0d grids: %0d peak and %0d summary words checked",
             n_accepted, grids_done, peaks_seen, summaries_seen);
    $display("sizes 0, 1..240, 1024 and 2047 incl. mid-grid cuts; %0d mismatches",
             err_count);
    if (err_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

`default_nettype wire
